FILE: hdl/ots_pkg.sv
// Shared types and constants for the sampled Otsu threshold block.
// Used by the controller, the datapath and the top level.
package ots_pkg;

  localparam int PIX_W      = 8;
  localparam int BIN_CNT    = 256;
  localparam int BIN_W      = 15;
  localparam int STEP_W     = 5;
  localparam int STEP_MAX   = 31;
  localparam logic [STEP_W-1:0] STEP_RESET = 5'd6;
  localparam logic [PIX_W-1:0]  THR_RESET  = 8'd120;

  localparam int DEF_IMAGE_WIDTH  = 188;
  localparam int DEF_IMAGE_HEIGHT = 120;

  // accumulator widths
  localparam int WB_W   = 23;   // class weight, sum of all bins
  localparam int SUM_W  = 31;   // grey sums
  localparam int PROD_W = 46;   // s_b*T, S*w_b and their difference
  localparam int DEN_W  = 30;   // w_b*w_f
  localparam int SQ_W   = 92;   // d^2
  localparam int CMP_W  = 122;  // d^2 * den, cross products

  // serial multiplier operand widths
  localparam int MUL_P_W = CMP_W;
  localparam int MUL_B_W = PROD_W;

  typedef enum logic [2:0] {
    MS_A   = 3'd0,  // s_b * total
    MS_B   = 3'd1,  // sum_all * w_b
    MS_DEN = 3'd2,  // w_b * w_f
    MS_SQ  = 3'd3,  // d * d
    MS_X   = 3'd4,  // d^2 * best_den
    MS_Y   = 3'd5   // best_d^2 * den
  } mul_step_t;

  typedef struct packed {
    logic      in_ready;
    logic      idx_inc;
    logic      clr_wr;
    logic      scan_init;
    logic      sum_acc;
    logic      scan_acc;
    logic      mul_start;
    logic      mul_cap;
    mul_step_t mul_sel;
    logic      cmp_upd;
    logic      out_load;
    logic      frame_clr;
  } ots_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic frame_done;
    logic eval_go;
    logic mul_busy;
    logic out_busy;
  } ots_sts_t;

endpackage

FILE: hdl/ots_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ots_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ots_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are zero. No dependencies.
module ots_mul #(
  parameter int P_W = 122,
  parameter int B_W = 46
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [P_W-1:0] a_in,
  input  logic [B_W-1:0] b_in,
  output logic           busy,
  output logic [P_W-1:0] prod
);

  logic [P_W-1:0] a_sh;
  logic [B_W-1:0] b_sh;

  assign busy = |b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_sh <= '0;
    end else if (start) begin
      b_sh <= b_in;
    end else if (busy) begin
      b_sh <= b_sh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      a_sh <= a_in;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
    end
  end

endmodule

FILE: hdl/ots_ctrl.sv
// Controller: sequences clearing, pixel intake, the two histogram passes
// and the per-bin compare. Depends on ots_pkg.
module ots_ctrl import ots_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ots_sts_t sts,
  output ots_cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_CLR      = 11'b000_0000_0001,
    ST_RUN      = 11'b000_0000_0010,
    ST_SETTLE   = 11'b000_0000_0100,
    ST_SUM_RD   = 11'b000_0000_1000,
    ST_SUM_ACC  = 11'b000_0001_0000,
    ST_SCAN_RD  = 11'b000_0010_0000,
    ST_SCAN_ACC = 11'b000_0100_0000,
    ST_MUL_GO   = 11'b000_1000_0000,
    ST_MUL_WAIT = 11'b001_0000_0000,
    ST_CMP      = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_t;

  state_t    state, state_next;
  mul_step_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      step  <= MS_A;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.mul_sel = step;
    case (state)
      ST_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.in_ready = 1'b1;
        if (sts.frame_done) state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        // last pixel's bin update lands this cycle
        cmd.scan_init = 1'b1;
        state_next = ST_SUM_RD;
      end
      ST_SUM_RD: state_next = ST_SUM_ACC;
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = sts.idx_last ? ST_SCAN_RD : ST_SUM_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_ACC;
      ST_SCAN_ACC: begin
        cmd.scan_acc = 1'b1;
        cmd.clr_wr   = 1'b1;
        if (sts.eval_go) begin
          step_next  = MS_A;
          state_next = ST_MUL_GO;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = sts.idx_last ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (!sts.mul_busy) begin
          cmd.mul_cap = 1'b1;
          case (step)
            MS_A:    begin step_next = MS_B;   state_next = ST_MUL_GO; end
            MS_B:    begin step_next = MS_DEN; state_next = ST_MUL_GO; end
            MS_DEN:  begin step_next = MS_SQ;  state_next = ST_MUL_GO; end
            MS_SQ:   begin step_next = MS_X;   state_next = ST_MUL_GO; end
            MS_X:    begin step_next = MS_Y;   state_next = ST_MUL_GO; end
            default: state_next = ST_CMP;
          endcase
        end
      end
      ST_CMP: begin
        cmd.cmp_upd = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = sts.idx_last ? ST_DONE : ST_SCAN_RD;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.frame_clr = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_CLR;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a pending transaction");

  a_frame_scan: assert property (@(posedge clk) disable iff (rst)
    sts.frame_done |=> state == ST_SETTLE)
    else $error("frame end did not start the scan");

endmodule

FILE: hdl/ots_dp.sv
// Datapath: raster position and sampling, histogram RAM with update
// forwarding, scan accumulators, serial multiplier, result register.
// Depends on ots_pkg, ots_ram, ots_mul.
module ots_dp import ots_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  ots_cmd_t          cmd,
  output ots_sts_t          sts,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [PIX_W-1:0]  m_tdata,
  output logic              m_tuser,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT + 1);
  localparam int IDX_W = $clog2(BIN_CNT);

  // ---------------- configuration and raster position ----------------
  logic [STEP_W-1:0] sample_step, step_eff;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [STEP_W-1:0] col_mod [1:STEP_MAX];
  logic [STEP_W-1:0] row_mod [1:STEP_MAX];
  logic [BIN_W-1:0]  sample_count;
  logic              accept, counted, col_wrap, row_adv;

  assign s_tready = cmd.in_ready;
  assign accept   = s_tvalid && cmd.in_ready;
  assign step_eff = (sample_step == '0) ? STEP_W'(1) : sample_step;
  assign counted  = (row < ROW_W'(IMAGE_HEIGHT)) && (row_mod[step_eff] == '0)
                    && (col_mod[step_eff] == '0);
  assign col_wrap = (col == COL_W'(IMAGE_WIDTH - 1));
  assign row_adv  = col_wrap && (row < ROW_W'(IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_step <= STEP_RESET;
    end else if (cfg_we) begin
      sample_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clr) begin
      col          <= '0;
      row          <= '0;
      sample_count <= '0;
    end else if (accept) begin
      col <= col_wrap ? '0 : col + COL_W'(1);
      if (row_adv) row <= row + ROW_W'(1);
      if (counted) sample_count <= sample_count + BIN_W'(1);
    end
  end

  // position modulo every possible step, so a step change takes effect at once
  for (genvar s = 1; s <= STEP_MAX; s++) begin : g_mod
    always_ff @(posedge clk) begin
      if (rst || cmd.frame_clr) begin
        col_mod[s] <= '0;
        row_mod[s] <= '0;
      end else if (accept) begin
        if (col_wrap || col_mod[s] == STEP_W'(s - 1)) col_mod[s] <= '0;
        else col_mod[s] <= col_mod[s] + STEP_W'(1);
        if (row_adv) begin
          if (row_mod[s] == STEP_W'(s - 1)) row_mod[s] <= '0;
          else row_mod[s] <= row_mod[s] + STEP_W'(1);
        end
      end
    end
  end

  // ---------------- histogram memory ----------------
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] raddr, waddr, pix_q;
  logic [BIN_W-1:0] rdata, wdata, fwd_q;
  logic             we, cnt_q, hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      cnt_q <= 1'b0;
    end else begin
      if (cmd.idx_inc) idx <= idx + IDX_W'(1);
      cnt_q <= accept && counted;
    end
  end

  assign raddr = cmd.in_ready ? s_tdata : idx;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cnt_q) begin
      we    = 1'b1;
      waddr = pix_q;
      wdata = (hit_q ? fwd_q : rdata) + BIN_W'(1);
    end
  end

  // a write at the same edge as the read returns stale data: forward it
  always_ff @(posedge clk) begin
    pix_q <= s_tdata;
    hit_q <= we && (waddr == raddr);
    fwd_q <= wdata;
  end

  ots_ram #(.WIDTH(BIN_W), .DEPTH(BIN_CNT)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------- scan accumulators ----------------
  logic [SUM_W-1:0]  sum_all, s_b;
  logic [WB_W-1:0]   w_b, wb_new, bin_wsum;
  logic [PROD_W-1:0] a_val, b_val, d_val;
  logic [DEN_W-1:0]  den, best_den;
  logic [SQ_W-1:0]   sq, best_sq;
  logic [CMP_W-1:0]  x_val, y_val;
  logic              found;
  logic [PIX_W-1:0]  last_thr;

  assign bin_wsum = WB_W'(idx) * WB_W'(rdata);
  assign wb_new   = w_b + WB_W'(rdata);
  assign d_val    = (a_val >= b_val) ? a_val - b_val : b_val - a_val;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      sum_all  <= '0;
      s_b      <= '0;
      w_b      <= '0;
      best_den <= DEN_W'(1);
      best_sq  <= '0;
    end else begin
      if (cmd.sum_acc) sum_all <= sum_all + SUM_W'(bin_wsum);
      if (cmd.scan_acc) begin
        w_b <= wb_new;
        s_b <= s_b + SUM_W'(bin_wsum);
      end
      if (cmd.cmp_upd && (!found || x_val > y_val)) begin
        best_den <= den;
        best_sq  <= sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      last_thr <= THR_RESET;
    end else if (cmd.scan_init) begin
      found <= 1'b0;
    end else if (cmd.cmp_upd && (!found || x_val > y_val)) begin
      found    <= 1'b1;
      last_thr <= idx;
    end
  end

  // ---------------- shared multiplier ----------------
  logic [MUL_P_W-1:0] mul_a, mul_p;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_busy;

  always_comb begin
    case (cmd.mul_sel)
      MS_A: begin
        mul_a = MUL_P_W'(s_b);
        mul_b = MUL_B_W'(sample_count);
      end
      MS_B: begin
        mul_a = MUL_P_W'(sum_all);
        mul_b = MUL_B_W'(w_b);
      end
      MS_DEN: begin
        mul_a = MUL_P_W'(w_b);
        mul_b = MUL_B_W'(WB_W'(sample_count) - w_b);
      end
      MS_SQ: begin
        mul_a = MUL_P_W'(d_val);
        mul_b = MUL_B_W'(d_val);
      end
      MS_X: begin
        mul_a = MUL_P_W'(sq);
        mul_b = MUL_B_W'(best_den);
      end
      MS_Y: begin
        mul_a = MUL_P_W'(best_sq);
        mul_b = MUL_B_W'(den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ots_mul #(.P_W(MUL_P_W), .B_W(MUL_B_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .busy  (mul_busy),
    .prod  (mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_cap) begin
      case (cmd.mul_sel)
        MS_A:    a_val <= mul_p[PROD_W-1:0];
        MS_B:    b_val <= mul_p[PROD_W-1:0];
        MS_DEN:  den   <= mul_p[DEN_W-1:0];
        MS_SQ:   sq    <= mul_p[SQ_W-1:0];
        MS_X:    x_val <= mul_p;
        MS_Y:    y_val <= mul_p;
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= last_thr;
      m_tuser <= !found;
    end
  end

  assign sts.idx_last   = (idx == IDX_W'(BIN_CNT - 1));
  assign sts.frame_done = accept && s_tlast;
  assign sts.eval_go    = (sample_count != '0) && (wb_new != '0)
                          && (wb_new < WB_W'(sample_count));
  assign sts.mul_busy   = mul_busy;
  assign sts.out_busy   = m_tvalid;

endmodule

FILE: hdl/otsu_threshold_sampled_unit.sv
// Otsu threshold over a sub-sampled grey frame: top level.
// Depends on ots_pkg, ots_ctrl, ots_dp.
//
// Pixels are taken one per cycle in raster order; tlast marks the frame's
// last pixel. After that pixel the block stops taking pixels and scans the
// 256-bin histogram: one pass for the grey sum, with a read state and an
// accumulate state per bin, then a second pass that also clears it. Each bin
// that splits the samples costs six products on one shift-and-add multiplier,
// one cycle per multiplier bit, and the multiplier sets the length of the
// frame-end scan. One threshold transaction is sent per frame; pixels are
// taken again once it is loaded into the output register. After reset a pass
// over all 256 bins clears the histogram before the first pixel is taken.
module otsu_threshold_sampled_unit import ots_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,   // [7:0] pixel
  input  logic              s_tlast,   // frame_end
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [PIX_W-1:0]  m_tdata,   // [7:0] threshold
  output logic              m_tuser,   // [0] kept_previous
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata  // sample_step
);

  ots_cmd_t cmd;
  ots_sts_t sts;

  ots_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ots_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule
